### sv/msbbuf_pkg.sv
`default_nettype none
package msbbuf_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PTR_W   = 16;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned IN_W    = 32;
  localparam int unsigned OUT_W   = 48;
  localparam int unsigned BIT_CAP = 65528;

  localparam logic [PTR_W-1:0] RP_MAX = 16'hFFFF;
  localparam logic [CNT_W-1:0] FULL_COUNT = 4'd8;

  typedef enum logic [2:0] {
    KIND_WRITE    = 3'd0,
    KIND_READ     = 3'd1,
    KIND_ALIGN_WR = 3'd2,
    KIND_ALIGN_RD = 3'd3,
    KIND_SKIP_RD  = 3'd4,
    KIND_CLEAR    = 3'd5,
    KIND_SET_WP   = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_READ_FAIL = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WMRG,
    S_WHI,
    S_RLO,
    S_RHI
  } state_e;

  typedef enum logic [1:0] {
    WSEL_FULL,
    WSEL_MERGE,
    WSEL_HIGH
  } wsel_e;

  typedef struct packed {
    logic  load;
    logic  mem_req;
    logic  mem_we;
    logic  addr_hi;
    wsel_e wsel;
    logic  lo_cap;
    logic  fin;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  write_go;
    logic  w_off_zero;
    logic  w_straddle;
    logic  read_go;
    logic  r_straddle;
    logic  out_free;
  } sts_t;

endpackage
`default_nettype wire

### sv/msbbuf_ctrl.sv
`default_nettype none
module msbbuf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  msbbuf_pkg::sts_t   sts_i,
  output msbbuf_pkg::cmd_t   cmd_o
);
  import msbbuf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
          if (sts_i.kind == KIND_WRITE && sts_i.write_go && !sts_i.w_off_zero) begin
            state_d = S_WMRG;
          end else if (sts_i.kind == KIND_READ && sts_i.read_go) begin
            state_d = S_RLO;
          end
        end
      end
      S_WMRG: state_d = sts_i.w_straddle ? S_WHI : S_IDLE;
      S_WHI:  state_d = S_IDLE;
      S_RLO:  state_d = sts_i.r_straddle ? S_RHI : S_IDLE;
      S_RHI:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.wsel = WSEL_FULL;
    s_tready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.load = s_tvalid_i;
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          if (sts_i.kind == KIND_WRITE && sts_i.write_go) begin
            cmd_o.mem_req = 1'b1;
            if (sts_i.w_off_zero) begin
              // whole byte replaced, no merge needed
              cmd_o.mem_we = 1'b1;
              cmd_o.fin    = 1'b1;
            end
          end else if (sts_i.kind == KIND_READ && sts_i.read_go) begin
            cmd_o.mem_req = 1'b1;
          end else begin
            cmd_o.fin = 1'b1;
          end
        end
      end
      S_WMRG: begin
        cmd_o.mem_req = 1'b1;
        cmd_o.mem_we  = 1'b1;
        cmd_o.wsel    = WSEL_MERGE;
        cmd_o.fin     = !sts_i.w_straddle;
      end
      S_WHI: begin
        cmd_o.mem_req = 1'b1;
        cmd_o.mem_we  = 1'b1;
        cmd_o.addr_hi = 1'b1;
        cmd_o.wsel    = WSEL_HIGH;
        cmd_o.fin     = 1'b1;
      end
      S_RLO: begin
        cmd_o.lo_cap  = 1'b1;
        cmd_o.mem_req = sts_i.r_straddle;
        cmd_o.addr_hi = 1'b1;
        cmd_o.fin     = !sts_i.r_straddle;
      end
      S_RHI: begin
        cmd_o.fin = 1'b1;
      end
      default: begin
        cmd_o.fin = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/msbbuf_dp.sv
`default_nettype none
module msbbuf_dp #(
  parameter int unsigned STORE_BYTES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [msbbuf_pkg::IN_W-1:0]       s_tdata_i,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [msbbuf_pkg::OUT_W-1:0]      m_tdata_o,
  input  msbbuf_pkg::cmd_t                  cmd_i,
  output msbbuf_pkg::sts_t                  sts_o
);
  import msbbuf_pkg::*;

  localparam int unsigned CAP_BITS   = STORE_BYTES * 8;
  localparam int unsigned LIMIT_BITS = (CAP_BITS < BIT_CAP) ? CAP_BITS : BIT_CAP;
  localparam int unsigned DEPTH      = LIMIT_BITS / 8;
  localparam int unsigned AW         = $clog2(DEPTH);
  localparam logic [PTR_W:0] LIMIT17 = (PTR_W+1)'(LIMIT_BITS);

  // latched item
  kind_e              kind_q;
  logic [BYTE_W-1:0]  data_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               ra_q;
  logic [PTR_W-1:0]   pos_q;

  logic [PTR_W-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [BYTE_W-1:0]  lo_q;
  logic [BYTE_W-1:0]  rdata_q;
  logic [BYTE_W-1:0]  store_q [DEPTH];

  logic               out_valid_q;
  logic [BYTE_W-1:0]  out_rd_q;
  status_e            out_st_q;
  logic [PTR_W-1:0]   out_wp_q, out_rp_q;

  logic [CNT_W-1:0]   n;
  logic [BYTE_W-1:0]  tmask, wb_al, wb, wlo, whi;
  logic [2:0]         woff, roff;
  logic [CNT_W-1:0]   wroom, rroom;
  logic [PTR_W:0]     wp_plus_n, rp_plus_n, wp_round, rp_round, rp_skip;
  logic               write_go, read_go, w_straddle, r_straddle;
  logic [BYTE_W-1:0]  rl, rh, rv, rd_val;
  logic [AW-1:0]      base, addr;
  logic [BYTE_W-1:0]  wdata;
  logic [BYTE_W-1:0]  rd_d;
  status_e            st_d;

  assign n     = (cnt_q > FULL_COUNT) ? FULL_COUNT : cnt_q;
  assign tmask = ~(8'hFF >> n);

  // write side
  assign wp_plus_n  = {1'b0, wp_q} + (PTR_W+1)'(n);
  assign write_go   = (n != '0) && (wp_plus_n <= LIMIT17);
  assign wb_al      = (ra_q && n < FULL_COUNT) ? (data_q << (FULL_COUNT - n)) : data_q;
  assign wb         = wb_al & tmask;
  assign woff       = wp_q[2:0];
  assign wroom      = FULL_COUNT - {1'b0, woff};
  assign wlo        = wb >> woff;
  assign whi        = wb << wroom;
  assign w_straddle = (woff != 3'd0) && (n > wroom);

  // read side
  assign rp_plus_n  = {1'b0, rp_q} + (PTR_W+1)'(n);
  assign read_go    = (n != '0) && (rp_plus_n <= {1'b0, wp_q});
  assign roff       = rp_q[2:0];
  assign rroom      = FULL_COUNT - {1'b0, roff};
  assign r_straddle = (roff != 3'd0) && (n > rroom);
  assign rl         = r_straddle ? lo_q : rdata_q;
  assign rh         = r_straddle ? (rdata_q >> rroom) : '0;
  assign rv         = ((rl << roff) | rh) & tmask;
  assign rd_val     = (ra_q && n < FULL_COUNT) ? (rv >> (FULL_COUNT - n)) : rv;

  assign wp_round = ({1'b0, wp_q} + (PTR_W+1)'(7)) & ~(PTR_W+1)'(7);
  assign rp_round = ({1'b0, rp_q} + (PTR_W+1)'(7)) & ~(PTR_W+1)'(7);
  assign rp_skip  = {1'b0, rp_q} + {1'b0, pos_q};

  always_comb begin
    wp_d = wp_q;
    rp_d = rp_q;
    st_d = ST_OK;
    rd_d = '0;
    case (kind_q)
      KIND_WRITE: begin
        if (write_go) wp_d = wp_plus_n[PTR_W-1:0];
        else if (n != '0) st_d = ST_FULL;
      end
      KIND_READ: begin
        if (read_go) begin
          rp_d = rp_plus_n[PTR_W-1:0];
          rd_d = rd_val;
        end else begin
          st_d = ST_READ_FAIL;
        end
      end
      KIND_ALIGN_WR: begin
        wp_d = (wp_round > LIMIT17) ? LIMIT17[PTR_W-1:0] : wp_round[PTR_W-1:0];
      end
      KIND_ALIGN_RD: begin
        rp_d = rp_round[PTR_W] ? RP_MAX : rp_round[PTR_W-1:0];
      end
      KIND_SKIP_RD: begin
        rp_d = rp_skip[PTR_W] ? RP_MAX : rp_skip[PTR_W-1:0];
      end
      KIND_CLEAR: begin
        wp_d = '0;
        rp_d = '0;
      end
      KIND_SET_WP: begin
        if ({1'b0, pos_q} > LIMIT17) begin
          wp_d = LIMIT17[PTR_W-1:0];
          st_d = ST_FULL;
        end else begin
          wp_d = pos_q;
        end
      end
      default: begin
        wp_d = wp_q;
      end
    endcase
  end

  // byte store, single port with registered read
  assign base = (kind_q == KIND_WRITE) ? wp_q[AW+2:3] : rp_q[AW+2:3];
  assign addr = cmd_i.addr_hi ? base + AW'(1) : base;

  always_comb begin
    case (cmd_i.wsel)
      WSEL_MERGE: wdata = rdata_q | wlo;
      WSEL_HIGH:  wdata = whi;
      default:    wdata = wb;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_req) begin
      if (cmd_i.mem_we) store_q[addr] <= wdata;
      else              rdata_q <= store_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_e'(s_tdata_i[2:0]);
      data_q <= s_tdata_i[10:3];
      cnt_q  <= s_tdata_i[14:11];
      ra_q   <= s_tdata_i[15];
      pos_q  <= s_tdata_i[31:16];
    end
    if (cmd_i.lo_cap) lo_q <= rdata_q;
    if (cmd_i.fin) begin
      out_rd_q <= rd_d;
      out_st_q <= st_d;
      out_wp_q <= wp_d;
      out_rp_q <= rp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.fin) begin
        wp_q <= wp_d;
        rp_q <= rp_d;
      end
      if (cmd_i.fin)       out_valid_q <= 1'b1;
      else if (m_tready_i) out_valid_q <= 1'b0;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {6'd0, out_rp_q, out_wp_q, out_st_q, out_rd_q};

  assign sts_o.kind       = kind_q;
  assign sts_o.write_go   = write_go;
  assign sts_o.w_off_zero = (woff == 3'd0);
  assign sts_o.w_straddle = w_straddle;
  assign sts_o.read_go    = read_go;
  assign sts_o.r_straddle = r_straddle;
  assign sts_o.out_free   = !out_valid_q || m_tready_i;

endmodule
`default_nettype wire

### sv/msb_first_bit_stream_buffer.sv
`default_nettype none
// Bit stream buffer: packs 1 to 8 bits MSB first at the write pointer into a byte store
// and unpacks them again at the read pointer; other item kinds align, skip, clear or set
// the pointers. Every item gives exactly one result item with the read data, a status
// and both pointers after the item. An item is taken only when the block is idle; it
// then enters the execute state, which alone serves pointer-only kinds, failed accesses
// and byte-aligned writes. A write at a bit offset adds a merge write of the old byte, a
// read adds a step that takes the registered read data, and a field that straddles two
// bytes adds a further step for the second byte; the single-port store with its
// registered read data and the read-modify-write of a partly filled byte set these
// steps. The result sits in an output register; while an earlier result still waits
// there, the next item holds right after acceptance until that result is taken.
module msb_first_bit_stream_buffer #(
  parameter int unsigned STORE_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // kind[2:0], data[10:3], bit_count[14:11], right_aligned[15], position[31:16]
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_data[7:0], status[9:8], write_position[25:10], read_position[41:26], zero pad
  output logic [47:0] m_axis_tdata_o
);
  import msbbuf_pkg::*;

  localparam int unsigned CAP_BITS   = STORE_BYTES * 8;
  localparam int unsigned LIMIT_BITS = (CAP_BITS < BIT_CAP) ? CAP_BITS : BIT_CAP;

  cmd_t cmd;
  sts_t sts;

  msbbuf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  msbbuf_dp #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

`ifndef SYNTHESIS
  a_wp_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ({1'b0, m_axis_tdata_o[25:10]} <= 17'(LIMIT_BITS)))
    else $error("write pointer beyond store");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[9:8] != 2'd3))
    else $error("bad status code");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("item accepted while busy");

  a_no_load_on_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.mem_req || cmd.fin) |-> !cmd.load)
    else $error("item latched during store access");
`endif

endmodule
`default_nettype wire
